/* rtl/double_to_decimal_text_core_assert.svh */
// Assertion macros for the decimal text formatter.
`ifndef DOUBLE_TO_DECIMAL_TEXT_CORE_ASSERT_SVH
`define DOUBLE_TO_DECIMAL_TEXT_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define DTD_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m failed");
`define DTD_ASSERT_NR(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("%m failed");
`else
`define DTD_ASSERT(label, clk, rst_n, prop)
`define DTD_ASSERT_NR(label, clk, prop)
`endif
`endif

/* rtl/dtd_pkg.sv */
package dtd_pkg;
  localparam int FracDigits = 6;
  localparam int FracPow = 1000000;
  localparam int FracPowW = 20;
  localparam int TextMax = 32;
  localparam int TextIdxW = 5;
  localparam logic [7:0] ChN = 8'h4e;
  localparam logic [7:0] ChA = 8'h61;
  localparam logic [7:0] ChMinus = 8'h2d;
  localparam logic [7:0] ChDot = 8'h2e;
  localparam logic [7:0] ChZero = 8'h30;
  localparam logic [1:0] StOk = 2'd0;
  localparam logic [1:0] StFit = 2'd1;
  localparam logic [1:0] StRange = 2'd2;
  localparam logic [10:0] ExpMax = 11'h7ff;
  localparam logic [10:0] ExpBias = 11'd1023;

  typedef struct packed {
    logic [7:0] text_char;
    logic       last_char;
    logic [1:0] status;
  } dtd_word_t;

  typedef struct packed {
    logic        start;
    logic [63:0] whole;
  } dtd_conv_req_t;

  typedef struct packed {
    logic       busy;
    logic       done;
    logic [3:0] digit;
    logic       digit_valid;
    logic       last_digit;
  } dtd_conv_sts_t;
endpackage

/* rtl/dtd_if.sv */
interface dtd_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] value_bits;
  modport source (output valid, output value_bits, input ready);
  modport sink (input valid, input value_bits, output ready);
endinterface

interface dtd_out_if;
  import dtd_pkg::*;
  logic       valid;
  logic       ready;
  logic [7:0] text_char;
  logic       last_char;
  logic [1:0] status;
  modport source (output valid, output text_char, output last_char, output status,
                  input ready);
  modport sink (input valid, input text_char, input last_char, input status,
                output ready);
endinterface

/* rtl/dtd_conv.sv */
// Shift-and-add-3 converter: 64 shifts of double dabble, then digits
// are read out most significant first, leading zeros skipped.
module dtd_conv
  import dtd_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  dtd_conv_req_t req,
  output dtd_conv_sts_t sts
);
  typedef enum logic [2:0] {
    C_IDLE = 3'b001,
    C_SHIFT = 3'b010,
    C_OUT = 3'b100
  } cstate_t;

  cstate_t     st_r, st_nxt;
  logic [63:0] bin_r, bin_nxt;
  logic [79:0] bcd_r, bcd_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic [4:0]  pos_r, pos_nxt;
  logic        seen_r, seen_nxt;
  logic [79:0] adj;
  logic [3:0]  cur;

  always_comb begin
    for (int k = 0; k < 20; k++) begin
      adj[k*4 +: 4] = (bcd_r[k*4 +: 4] >= 4'd5) ? bcd_r[k*4 +: 4] + 4'd3
                                                : bcd_r[k*4 +: 4];
    end
  end

  assign cur = bcd_r[pos_r*4 +: 4];

  always_comb begin
    st_nxt = st_r;
    bin_nxt = bin_r;
    bcd_nxt = bcd_r;
    cnt_nxt = cnt_r;
    pos_nxt = pos_r;
    seen_nxt = seen_r;
    sts.digit = cur;
    sts.digit_valid = 1'b0;
    sts.last_digit = (pos_r == 5'd0);
    sts.done = 1'b0;
    case (st_r)
      C_IDLE: begin
        if (req.start) begin
          bin_nxt = req.whole;
          bcd_nxt = '0;
          cnt_nxt = '0;
          st_nxt = C_SHIFT;
        end
      end
      C_SHIFT: begin
        {bcd_nxt, bin_nxt} = {adj[78:0], bin_r, 1'b0};
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == 7'd63) begin
          st_nxt = C_OUT;
          pos_nxt = 5'd19;
          seen_nxt = 1'b0;
        end
      end
      C_OUT: begin
        sts.digit_valid = seen_r || (cur != 4'd0) || (pos_r == 5'd0);
        if (sts.digit_valid) seen_nxt = 1'b1;
        pos_nxt = pos_r - 5'd1;
        if (pos_r == 5'd0) begin
          sts.done = 1'b1;
          st_nxt = C_IDLE;
        end
      end
      default: st_nxt = C_IDLE;
    endcase
    sts.busy = (st_r != C_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= C_IDLE;
    end else begin
      st_r <= st_nxt;
    end
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
    cnt_r <= cnt_nxt;
    pos_r <= pos_nxt;
    seen_r <= seen_nxt;
  end
endmodule

/* rtl/double_to_decimal_text_core.sv */
// Channel  Dir  Payload
// in       in   value_bits[63:0]
// out      out  text_char[7:0], last_char, status[1:0]
// cfg      in   cfg_wdata[5:0] text capacity
// A finite word passes through decode, the fraction product when it has a fraction,
// the double dabble unit (start, 64 shifts, digit reads), the point and fraction
// digits, trailing-zero trim and then one word out per cycle while out.ready is high.
// NaN and out-of-range words skip the conversion; a too-long text is found at output.
// Reset is synchronous; the output register holds while out.ready is low, and no new
// word is taken until the last word out has left.
module double_to_decimal_text_core
  import dtd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  dtd_in_if.sink      in_ch,
  dtd_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [5:0]  cfg_wdata
);
`include "double_to_decimal_text_core_assert.svh"

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_DEC   = 8'b0000_0010,
    S_FRAC  = 8'b0000_0100,
    S_CONV  = 8'b0000_1000,
    S_FDIG  = 8'b0001_0000,
    S_TRIM  = 8'b0010_0000,
    S_EMIT  = 8'b0100_0000,
    S_ERR   = 8'b1000_0000
  } state_t;

  state_t        st_r, st_nxt;
  logic [5:0]    cap_r;
  logic [63:0]   v_r, v_nxt;
  logic [63:0]   whole_r, whole_nxt;
  logic [52:0]   fm_r, fm_nxt;
  logic [6:0]    sh_r, sh_nxt;
  logic          hasf_r, hasf_nxt;
  logic [72:0]   prod_r, prod_nxt;
  logic [4:0]    pcnt_r, pcnt_nxt;
  logic [FracPowW-1:0] d_r, d_nxt;
  logic [7:0]    txt_r [TextMax];
  logic [TextIdxW-1:0] n_r, n_nxt, ip_r, ip_nxt;
  logic [2:0]    fcnt_r, fcnt_nxt;
  logic [1:0]    err_r, err_nxt;
  logic          wen;
  logic [TextIdxW-1:0] waddr;
  logic [7:0]    wdat;
  logic          ovalid_r;
  dtd_word_t     oword_r, oword_nxt;
  logic          oload;
  dtd_conv_req_t creq;
  dtd_conv_sts_t csts;
  logic [10:0]   ex;
  logic [51:0]   mant;
  logic [52:0]   m;
  logic [6:0]    s;
  logic [72:0]   pmask_prod;
  logic [FracPowW-1:0] dq;
  logic [3:0]    drem;

  dtd_conv u_conv (.clk(clk), .rst_n(rst_n), .req(creq), .sts(csts));

  assign ex = v_r[62:52];
  assign mant = v_r[51:0];
  assign m = {1'b1, mant};
  assign s = 7'(12'd1075 - {1'b0, ex});
  assign dq = FracPowW'(({24'd0, d_r} * 44'd838861) >> 23);
  assign drem = 4'(d_r - FracPowW'(dq * 4'd10));
  assign pmask_prod = prod_r >> sh_r;

  assign in_ch.ready = (st_r == S_IDLE) && !ovalid_r;
  assign oload = !ovalid_r || out_ch.ready;
  assign out_ch.valid = ovalid_r;
  assign out_ch.text_char = oword_r.text_char;
  assign out_ch.last_char = oword_r.last_char;
  assign out_ch.status = oword_r.status;

  always_comb begin
    st_nxt = st_r;
    v_nxt = v_r;
    whole_nxt = whole_r;
    fm_nxt = fm_r;
    sh_nxt = sh_r;
    hasf_nxt = hasf_r;
    prod_nxt = prod_r;
    pcnt_nxt = pcnt_r;
    d_nxt = d_r;
    n_nxt = n_r;
    ip_nxt = ip_r;
    fcnt_nxt = fcnt_r;
    err_nxt = err_r;
    wen = 1'b0;
    waddr = n_r;
    wdat = ChZero;
    creq.start = 1'b0;
    creq.whole = whole_r;
    oword_nxt = oword_r;
    case (st_r)
      S_IDLE: begin
        if (in_ch.valid && in_ch.ready) begin
          v_nxt = in_ch.value_bits;
          st_nxt = S_DEC;
        end
      end
      S_DEC: begin
        n_nxt = '0;
        whole_nxt = '0;
        hasf_nxt = 1'b0;
        d_nxt = '0;
        if (ex == ExpMax && mant != '0) begin
          err_nxt = StOk;
          st_nxt = S_EMIT;
          n_nxt = 5'd3;
        end else if (ex == ExpMax || ex >= ExpBias + 11'd63) begin
          err_nxt = StRange;
          st_nxt = S_ERR;
        end else begin
          st_nxt = S_CONV;
          if (v_r[63] && (ex != 0 || mant != 0)) begin
            wen = 1'b1;
            waddr = '0;
            wdat = ChMinus;
            n_nxt = 5'd1;
          end
          if (ex != 0 || mant != 0) begin
            if (ex >= 11'd1075) begin
              whole_nxt = {11'd0, m} << (ex - 11'd1075);
            end else if (ex != 0 && ex >= ExpBias - 11'd30) begin
              sh_nxt = s;
              if (s < 7'd64) begin
                whole_nxt = {11'd0, m} >> s;
                fm_nxt = m & ((53'd1 << s) - 53'd1);
              end else begin
                fm_nxt = m;
              end
              prod_nxt = '0;
              pcnt_nxt = '0;
              st_nxt = S_FRAC;
            end else begin
              hasf_nxt = 1'b1;
            end
          end
        end
      end
      S_FRAC: begin
        if (fm_r == '0) begin
          st_nxt = S_CONV;
        end else begin
          hasf_nxt = 1'b1;
          if (FracPow[pcnt_r]) prod_nxt = prod_r + ({20'd0, fm_r} << pcnt_r);
          pcnt_nxt = pcnt_r + 5'd1;
          if (pcnt_r == 5'(FracPowW - 1)) st_nxt = S_CONV;
        end
      end
      S_CONV: begin
        if (hasf_r && pcnt_r == 5'(FracPowW)) begin
          d_nxt = FracPowW'(pmask_prod);
          pcnt_nxt = '0;
        end
        if (!csts.busy && !creq.start && ip_r == '0) begin
          creq.start = 1'b1;
          ip_nxt = 5'd1;
        end else if (csts.busy) begin
          if (csts.digit_valid) begin
            wen = 1'b1;
            wdat = ChZero + {4'd0, csts.digit};
            n_nxt = n_r + 5'd1;
          end
          if (csts.done) begin
            ip_nxt = '0;
            if (hasf_r) begin
              n_nxt = n_r + 5'd2 + 5'(FracDigits);
              fcnt_nxt = 3'(FracDigits);
              st_nxt = S_FDIG;
            end else begin
              st_nxt = S_TRIM;
            end
          end
        end
      end
      S_FDIG: begin
        wen = 1'b1;
        if (fcnt_r == 3'(FracDigits)) begin
          waddr = n_r - 5'(FracDigits) - 5'd1;
          wdat = ChDot;
          fcnt_nxt = fcnt_r - 3'd1;
        end else begin
          waddr = n_r - 5'(FracDigits) + 5'(fcnt_r);
          wdat = ChZero + {4'd0, drem};
          d_nxt = dq;
          if (fcnt_r == '0) st_nxt = S_TRIM;
          else fcnt_nxt = fcnt_r - 3'd1;
        end
      end
      S_TRIM: begin
        if (hasf_r && txt_r[n_r - 5'd1] == ChZero && txt_r[n_r - 5'd2] != ChDot) begin
          n_nxt = n_r - 5'd1;
        end else begin
          err_nxt = StOk;
          st_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (({1'b0, n_r} + 6'd1) > cap_r || n_r == '0) begin
          err_nxt = StFit;
          st_nxt = S_ERR;
        end else if (oload) begin
          if (v_r[62:52] == ExpMax) begin
            oword_nxt.text_char = (ip_r == 5'd1) ? ChA : ChN;
          end else begin
            oword_nxt.text_char = txt_r[ip_r];
          end
          oword_nxt.last_char = (ip_r == n_r - 5'd1);
          oword_nxt.status = StOk;
          ip_nxt = ip_r + 5'd1;
          if (ip_r == n_r - 5'd1) begin
            ip_nxt = '0;
            st_nxt = S_IDLE;
          end
        end
      end
      S_ERR: begin
        if (oload) begin
          oword_nxt = '{text_char: 8'd0, last_char: 1'b1, status: err_r};
          ip_nxt = '0;
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      cap_r <= 6'd32;
      ovalid_r <= 1'b0;
      ip_r <= '0;
      pcnt_r <= '0;
    end else begin
      st_r <= st_nxt;
      ip_r <= ip_nxt;
      pcnt_r <= (st_r == S_FRAC && st_nxt == S_CONV && fm_r != '0) ? 5'(FracPowW)
                                                                  : pcnt_nxt;
      if (cfg_we) cap_r <= cfg_wdata;
      if ((st_r == S_EMIT && st_nxt != S_ERR && oload) || (st_r == S_ERR && oload)) begin
        ovalid_r <= 1'b1;
      end else if (out_ch.ready) begin
        ovalid_r <= 1'b0;
      end
    end
    v_r <= v_nxt;
    whole_r <= whole_nxt;
    fm_r <= fm_nxt;
    sh_r <= sh_nxt;
    hasf_r <= hasf_nxt;
    prod_r <= prod_nxt;
    d_r <= d_nxt;
    n_r <= n_nxt;
    fcnt_r <= fcnt_nxt;
    err_r <= err_nxt;
    oword_r <= oword_nxt;
    if (wen) txt_r[waddr] <= wdat;
  end

  `DTD_ASSERT(a_ready_idle, clk, rst_n, in_ch.ready |-> st_r == S_IDLE)
  `DTD_ASSERT(a_hold, clk, rst_n, out_ch.valid && !out_ch.ready |=> $stable(oword_r))
  `DTD_ASSERT(a_err_last, clk, rst_n, out_ch.valid && out_ch.status != StOk |-> out_ch.last_char)
endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import dtd_pkg::*;

  class text_scoreboard;
    dtd_word_t   expected_chars[$];
    int unsigned capacity;
    int          failures;

    function new();
      capacity = 32;
      failures = 0;
    endfunction

    function void push_error(logic [1:0] code);
      dtd_word_t w;
      w.text_char = 8'h00;
      w.last_char = 1'b1;
      w.status = code;
      expected_chars.push_back(w);
    endfunction

    function void note_value(logic [63:0] v);
      logic [10:0]  ex;
      logic [52:0]  m;
      logic [63:0]  whole;
      logic [63:0]  fm;
      logic [127:0] prod;
      logic [31:0]  d;
      logic [7:0]   txt[$];
      logic [7:0]   digs[$];
      logic [7:0]   fd[FracDigits];
      logic         nz;
      logic         has_frac;
      int           s;
      int           len;
      dtd_word_t    w;
      ex = v[62:52];
      m = {1'b1, v[51:0]};
      nz = (ex != 0) || (v[51:0] != 0);
      whole = 0;
      d = 0;
      has_frac = 0;
      if (ex == ExpMax && v[51:0] != 0) begin
        txt = '{ChN, ChA, ChN};
      end else if (ex == ExpMax || int'(ex) >= int'(ExpBias) + 63) begin
        push_error(StRange);
        return;
      end else begin
        if (nz) begin
          if (int'(ex) >= int'(ExpBias) + 52) begin
            whole = 64'(m) << (int'(ex) - int'(ExpBias) - 52);
          end else if (ex != 0 && int'(ex) >= int'(ExpBias) - 30) begin
            s = int'(ExpBias) + 52 - int'(ex);
            if (s < 64) begin
              whole = 64'(m) >> s;
              fm = 64'(m) & ((64'd1 << s) - 64'd1);
            end else begin
              fm = 64'(m);
            end
            if (fm != 0) begin
              has_frac = 1;
              prod = (128'(fm) * 128'(FracPow)) >> s;
              d = prod[31:0];
            end
          end else begin
            has_frac = 1;
          end
        end
        if (v[63] && nz) txt.push_back(ChMinus);
        do begin
          digs.push_front(ChZero + 8'(whole % 10));
          whole = whole / 10;
        end while (whole != 0);
        foreach (digs[i]) txt.push_back(digs[i]);
        if (has_frac) begin
          txt.push_back(ChDot);
          for (int i = FracDigits - 1; i >= 0; i--) begin
            fd[i] = ChZero + 8'(d % 10);
            d = d / 10;
          end
          len = FracDigits;
          while (len > 1 && fd[len - 1] == ChZero) len--;
          for (int i = 0; i < len; i++) txt.push_back(fd[i]);
        end
      end
      if (txt.size() + 1 > capacity) begin
        push_error(StFit);
        return;
      end
      foreach (txt[i]) begin
        w.text_char = txt[i];
        w.last_char = (i == txt.size() - 1);
        w.status = StOk;
        expected_chars.push_back(w);
      end
    endfunction

    function void check_char(dtd_word_t got);
      dtd_word_t exp_w;
      if (expected_chars.size() == 0) begin
        $error("unexpected word %h", got);
        failures++;
        return;
      end
      exp_w = expected_chars.pop_front();
      if (got.text_char !== exp_w.text_char) begin
        $error("text_char expected %h actual %h", exp_w.text_char, got.text_char);
        failures++;
      end
      if (got.last_char !== exp_w.last_char) begin
        $error("last_char expected %b actual %b", exp_w.last_char, got.last_char);
        failures++;
      end
      if (got.status !== exp_w.status) begin
        $error("status expected %0d actual %0d", exp_w.status, got.status);
        failures++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [5:0] cfg_wdata;
  dtd_in_if in_ch();
  dtd_out_if out_ch();
  text_scoreboard sb;
  int send_idle;
  int recv_idle;
  int words_seen;
  bit held;

  double_to_decimal_text_core uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("testbench: errors");
    $finish;
  end

  initial begin
    out_ch.ready = 0;
    words_seen = 0;
    held = 0;
    forever begin
      @(negedge clk);
      if (!held && words_seen >= 200) begin
        out_ch.ready <= 0;
        repeat (600) @(negedge clk);
        held = 1;
      end
      out_ch.ready <= rst_n && ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    dtd_word_t w;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      w.text_char = out_ch.text_char;
      w.last_char = out_ch.last_char;
      w.status = out_ch.status;
      sb.check_char(w);
      words_seen++;
    end
  end

  task automatic send_value(logic [63:0] bits);
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 0;
      @(negedge clk);
    end
    in_ch.valid <= 1;
    in_ch.value_bits <= bits;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_value(bits);
    @(negedge clk);
  endtask

  task automatic set_capacity(int unsigned cap);
    in_ch.valid <= 0;
    while (sb.expected_chars.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    cfg_we <= 1;
    cfg_wdata <= 6'(cap);
    @(negedge clk);
    cfg_we <= 0;
    sb.capacity = cap;
  endtask

  function automatic logic [63:0] random_value();
    logic [63:0] v;
    int pick;
    v = {$urandom, $urandom};
    pick = $urandom_range(99);
    if (pick < 70) v[62:52] = 11'($urandom_range(1090, 975));
    else if (pick < 78) v[62:52] = 11'd0;
    else if (pick < 84) v[62:52] = ExpMax;
    else if (pick < 88) v[51:0] = 52'd0;
    return v;
  endfunction

  initial begin
    logic [63:0] directed[$];
    int unsigned caps[$];
    sb = new();
    rst_n = 0;
    cfg_we = 0;
    cfg_wdata = 0;
    in_ch.valid = 0;
    in_ch.value_bits = 0;
    send_idle = 38;
    recv_idle = 70;
    repeat (4) @(negedge clk);
    rst_n = 1;
    directed = '{64'h0000000000000000, 64'h8000000000000000, 64'h3ff0000000000000,
                 64'hbff8000000000000, 64'h7ff8000000000000, 64'hfff0000000000001,
                 64'h7ff0000000000000, 64'hfff0000000000000, 64'h43e0000000000000,
                 64'h43dfffffffffffff, 64'hc3dfffffffffffff, 64'h3fb999999999999a,
                 64'h3e7ad7f29abcaf48, 64'h0000000000000001, 64'h800fffffffffffff,
                 64'h0010000000000000, 64'h405edd2f1a9fbe77, 64'h3fe0000000000000,
                 64'h3e10000000000000, 64'h3e0fffffffffffff, 64'h4331ffffffffffff,
                 64'h3eb0c6f7a0b5ed8d, 64'hc1cfffffffffffff, 64'hffffffffffffffff};
    foreach (directed[i]) send_value(directed[i]);
    caps = '{63, 0, 1, 5, 12, 20, 28, 32};
    foreach (caps[p]) begin
      set_capacity(caps[p]);
      if (p < 3) begin
        send_idle = 38;
        recv_idle = 70;
      end else if (p < 6) begin
        send_idle = 70;
        recv_idle = 38;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      repeat (11) send_value(random_value());
    end
    in_ch.valid <= 0;
    while (sb.expected_chars.size() != 0) @(negedge clk);
    repeat (150) @(negedge clk);
    if (sb.failures == 0 && sb.expected_chars.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end
endmodule

/* sim.f */
+incdir+rtl
rtl/dtd_pkg.sv
rtl/dtd_if.sv
rtl/dtd_conv.sv
rtl/double_to_decimal_text_core.sv
sim/testbench.sv
